FILE: hw/rtl/closed_cubic_bspline_evaluator_core_macros.svh
// assertion macros used by the evaluator core
`ifndef CLOSED_CUBIC_BSPLINE_EVALUATOR_CORE_MACROS_SVH
`define CLOSED_CUBIC_BSPLINE_EVALUATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CCB_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define CCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/ccbspl_pkg.sv
package ccbspl_pkg;

	// ring and sub-step sizes and datapath widths
	localparam int KNOTS    = 16;
	localparam int STEPS    = 16;
	localparam int KNOT_AW  = $clog2(KNOTS);
	localparam int STEP_W   = $clog2(STEPS);
	localparam int COORD_W  = 16;
	localparam int WEIGHT_W = 16;
	localparam int KNOT_W   = 3 * COORD_W;
	localparam int SAMPLE_W = 8;
	localparam int PROD_W   = COORD_W + WEIGHT_W + 1;
	localparam int ACC_W    = PROD_W + 2;

	// basis denominator 6 * STEPS^3
	localparam longint WDEN = 6 * STEPS * STEPS * STEPS;

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef weight_t [3:0] wset_t;
	typedef wset_t [STEPS-1:0] wtab_t;
	typedef logic [3:0][COORD_W-1:0] kset_t;
	typedef logic [3:0][PROD_W-1:0] prod_t;

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// basis weights for every sub-step, rounded half up, w1 takes the slack
	function automatic wtab_t build_weights();
		wtab_t  tab;
		longint n;
		longint s;
		longint w0;
		longint w2;
		longint w3;
		n = STEPS;
		for (int u = 0; u < STEPS; u++) begin
			s  = u;
			w0 = ((n - s) * (n - s) * (n - s) * 65536 + WDEN / 2) / WDEN;
			w2 = ((-3 * s * s * s + 3 * s * s * n + 3 * s * n * n + n * n * n) * 65536
				+ WDEN / 2) / WDEN;
			w3 = (s * s * s * 65536 + WDEN / 2) / WDEN;
			tab[u][0] = WEIGHT_W'(w0);
			tab[u][1] = WEIGHT_W'(65536 - w0 - w2 - w3);
			tab[u][2] = WEIGHT_W'(w2);
			tab[u][3] = WEIGHT_W'(w3);
		end
		return tab;
	endfunction

	localparam wtab_t WEIGHT_TABLE = build_weights();

endpackage

FILE: hw/rtl/closed_cubic_bspline_evaluator_core.sv
// an evaluate beat passes the knot ram read and weight, product and output registers
// throughput: one beat per cycle while in_stall is low, loads and evaluates alike; the
// four knot ram copies each give one read per cycle, so all four knots are read together
// reset: arst_n clears the stage valid bits at once; the knot ram is not cleared
// and a knot must be loaded before a segment that uses it is evaluated
`include "closed_cubic_bspline_evaluator_core_macros.svh"

module closed_cubic_bspline_evaluator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [3:0]                            knot_index,
	input  logic signed [15:0]                    knot_x,
	input  logic signed [15:0]                    knot_y,
	input  logic signed [15:0]                    knot_z,
	input  logic [3:0]                            segment,
	input  logic [3:0]                            sub_step,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [15:0]                    point_x,
	output logic signed [15:0]                    point_y,
	output logic signed [15:0]                    point_z,
	output logic [7:0]                            sample_number
);

	ccbspl_pkg::stage_en_t                   en;
	logic                                    in_acc;
	logic                                    eval_acc;
	logic                                    load_acc;
	logic                                    v_s1;
	logic                                    v_s2;
	logic                                    v_s3;
	ccbspl_pkg::wset_t                       weights_s1;
	logic [ccbspl_pkg::SAMPLE_W-1:0]         sample_s1;
	logic [ccbspl_pkg::SAMPLE_W-1:0]         sample_s2;
	logic [ccbspl_pkg::SAMPLE_W-1:0]         sample_s3;
	logic [3:0][ccbspl_pkg::KNOT_W-1:0]      knot_rd;
	ccbspl_pkg::kset_t                       coord_knots [3];
	logic signed [ccbspl_pkg::COORD_W-1:0]   coord_point [3];

	// stage advance, a stage moves when empty or when the next one moves
	always_comb begin
		en.s3 = !v_s3 || !out_stall;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall = !en.s1;
	assign in_acc   = in_valid && !in_stall;
	assign eval_acc = in_acc && (opcode == ccbspl_pkg::OP_EVAL);
	assign load_acc = in_acc && (opcode == ccbspl_pkg::OP_LOAD);

	// one knot ram copy per blend tap, all written together
	for (genvar i = 0; i < 4; i++) begin : g_bank
		ccbspl_knot_ram u_ram (
			.clk   (clk),
			.we    (load_acc),
			.waddr (knot_index),
			.wdata ({knot_z, knot_y, knot_x}),
			.re    (eval_acc),
			.raddr (segment + ccbspl_pkg::KNOT_AW'(i)),
			.rdata (knot_rd[i])
		);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= eval_acc;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// weights and sample position travel alongside
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			weights_s1 <= ccbspl_pkg::WEIGHT_TABLE[sub_step];
			sample_s1  <= {segment, sub_step};
		end
		if (en.s2) begin
			sample_s2 <= sample_s1;
		end
		if (en.s3) begin
			sample_s3 <= sample_s2;
		end
	end

	// split ram words into per-coordinate knot sets
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 4; i++) begin
				coord_knots[c][i] = knot_rd[i][c*ccbspl_pkg::COORD_W +: ccbspl_pkg::COORD_W];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_coord
		ccbspl_blend u_blend (
			.clk     (clk),
			.en      (en),
			.knots   (coord_knots[c]),
			.weights (weights_s1),
			.point   (coord_point[c])
		);
	end

	// output beat
	assign out_valid     = v_s3;
	assign point_x       = coord_point[0];
	assign point_y       = coord_point[1];
	assign point_z       = coord_point[2];
	assign sample_number = sample_s3;

	// a stall on the input only when every stage holds a beat
	`CCB_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2 && v_s3)
	// an accepted evaluate always lands in the first stage
	`CCB_ASSERT_NEXT(a_eval_enters, clk, arst_n, eval_acc, v_s1)
	// a moving second stage hands its sample position to the last stage
	`CCB_ASSERT_NEXT(a_sample_moves, clk, arst_n, v_s2 && en.s3,
		v_s3 && (sample_s3 == $past(sample_s2)))

endmodule

FILE: hw/rtl/ccbspl_knot_ram.sv
module ccbspl_knot_ram (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [ccbspl_pkg::KNOT_AW-1:0]       waddr,
	input  logic [ccbspl_pkg::KNOT_W-1:0]        wdata,
	input  logic                                 re,
	input  logic [ccbspl_pkg::KNOT_AW-1:0]       raddr,
	output logic [ccbspl_pkg::KNOT_W-1:0]        rdata
);

	logic [ccbspl_pkg::KNOT_W-1:0] mem_q [ccbspl_pkg::KNOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/ccbspl_blend.sv
module ccbspl_blend (
	input  logic                                 clk,
	input  ccbspl_pkg::stage_en_t                en,
	input  ccbspl_pkg::kset_t                    knots,
	input  ccbspl_pkg::wset_t                    weights,
	output logic signed [ccbspl_pkg::COORD_W-1:0] point
);

	ccbspl_pkg::prod_t                      prod_s2;
	logic signed [ccbspl_pkg::ACC_W-1:0]    acc;
	logic signed [ccbspl_pkg::COORD_W-1:0]  point_s3;

	// weighted knots, signed coordinate times unsigned weight
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= $signed(knots[i]) * $signed({1'b0, weights[i]});
			end
		end
	end

	// sum of four products plus half an output lsb
	always_comb begin
		acc = ccbspl_pkg::ACC_W'(32768);
		for (int i = 0; i < 4; i++) begin
			acc = acc + {{2{prod_s2[i][ccbspl_pkg::PROD_W-1]}}, prod_s2[i]};
		end
	end

	// round half up to q8.8
	always_ff @(posedge clk) begin
		if (en.s3) begin
			point_s3 <= acc[2*ccbspl_pkg::WEIGHT_W-1:ccbspl_pkg::WEIGHT_W];
		end
	end

	assign point = point_s3;

endmodule
